>>> rtl/assert_macros.svh
// Assertion helpers used by uuid_text_parser_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/utp_pkg.sv
package utp_pkg;

	localparam int unsigned NUM_BYTES = 16;
	localparam int unsigned CNT_W     = 5;
	localparam int unsigned IDX_W     = 4;

	localparam logic [7:0] CH_OPEN   = 8'h7B;
	localparam logic [7:0] CH_CLOSE  = 8'h7D;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;

	localparam logic [CNT_W-1:0] BYTES_FULL = CNT_W'(NUM_BYTES);

	// Classification of one input character.
	typedef struct packed {
		logic       is_hex;
		logic       is_hyphen;
		logic       is_open;
		logic       is_close;
		logic [3:0] nibble;
	} char_class_t;

endpackage

>>> rtl/uuid_text_parser_core.sv
// Channel  Dir  tdata bits                                   side bits
// s_       in   [7:0] character                              tlast = last
// m_       out  [63:0] uuid_high, [127:64] uuid_low          tuser = ok
//
// One character per cycle while no final character waits on a stalled
// result. A character is registered in stage 1; the parse state and the
// byte store update from it as it leaves stage 1, and a final character
// also loads the result register as it leaves. Reset clears the parse state
// and all valid flags; the byte store has no reset. A stalled result holds
// only a final character in stage 1; other characters keep flowing.
module uuid_text_parser_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] character
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] uuid_high, [127:64] uuid_low
	output logic         m_tuser    // [0] ok
);

`include "assert_macros.svh"

	// Stage 1: registered input transfer
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       go_s1;

	// Parse state
	logic                     at_start_q;
	logic                     brace_q;
	logic                     half_q;
	logic [3:0]               high_q;
	logic [utp_pkg::CNT_W-1:0] count_q;
	logic                     failed_q;
	logic [7:0]               bytes_q [utp_pkg::NUM_BYTES];

	utp_pkg::char_class_t cls;

	// Next state
	logic                     at_start_d;
	logic                     brace_d;
	logic                     half_d;
	logic [3:0]               high_d;
	logic [utp_pkg::CNT_W-1:0] count_d;
	logic                     failed_d;
	logic                     take;
	logic                     wr;
	logic                     good;
	logic [7:0]               wr_byte;
	logic [7:0]               bytes_d [utp_pkg::NUM_BYTES];
	logic [63:0]              hi_d;
	logic [63:0]              lo_d;

	// Advance stage 1 unless a final character waits on a full result slot.
	assign go_s1    = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	utp_char_class u_class (
		.character(char_s1),
		.cls      (cls)
	);

	assign wr_byte = {high_q, cls.nibble};

	always_comb begin
		at_start_d = at_start_q;
		brace_d    = brace_q;
		half_d     = half_q;
		high_d     = high_q;
		count_d    = count_q;
		failed_d   = failed_q;
		take       = 1'b0;
		wr         = 1'b0;

		if (at_start_q) begin
			at_start_d = 1'b0;
			// hold back a leading brace until the final character shows
			if (cls.is_open && !last_s1) begin
				brace_d = 1'b1;
			end else begin
				take = 1'b1;
			end
		end else if (last_s1 && brace_q && cls.is_close) begin
			// matching close brace: drop it
			take = 1'b0;
		end else begin
			if (brace_q && last_s1) begin
				failed_d = 1'b1;
			end
			take = 1'b1;
		end

		if (take && !failed_d && !cls.is_hyphen) begin
			if (!cls.is_hex) begin
				failed_d = 1'b1;
			end else if (half_q) begin
				if (count_q[utp_pkg::CNT_W-1]) begin
					// a seventeenth byte
					failed_d = 1'b1;
				end else begin
					wr      = 1'b1;
					count_d = count_q + 1'b1;
					half_d  = 1'b0;
				end
			end else begin
				high_d = cls.nibble;
				half_d = 1'b1;
			end
		end

		good = !failed_d && (count_d == utp_pkg::BYTES_FULL) && !half_d;

		if (last_s1) begin
			at_start_d = 1'b1;
			brace_d    = 1'b0;
			half_d     = 1'b0;
			high_d     = '0;
			count_d    = '0;
			failed_d   = 1'b0;
		end
	end

	// Byte store as seen after this cycle's write, for the result.
	always_comb begin
		for (int i = 0; i < utp_pkg::NUM_BYTES; i++) begin
			bytes_d[i] = bytes_q[i];
		end
		if (wr) begin
			bytes_d[count_q[utp_pkg::IDX_W-1:0]] = wr_byte;
		end
		for (int i = 0; i < 8; i++) begin
			hi_d[63-8*i -: 8] = bytes_d[i];
			lo_d[63-8*i -: 8] = bytes_d[i+8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			brace_q    <= 1'b0;
			half_q     <= 1'b0;
			high_q     <= '0;
			count_q    <= '0;
			failed_q   <= 1'b0;
		end else if (go_s1) begin
			at_start_q <= at_start_d;
			brace_q    <= brace_d;
			half_q     <= half_d;
			high_q     <= high_d;
			count_q    <= count_d;
			failed_q   <= failed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && wr) begin
			bytes_q[count_q[utp_pkg::IDX_W-1:0]] <= wr_byte;
		end
	end

	// Result register: load on a final character, clear the flag once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (go_s1 && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			m_tdata <= good ? {lo_d, hi_d} : '0;
			m_tuser <= good;
		end
	end

	`ASSERT_NEXT(a_result_loaded, clk, arst_n, go_s1 && last_s1, m_tvalid)
	`ASSERT_IMPL(a_fail_is_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0)
	`ASSERT_IMPL(a_start_clean, clk, arst_n, at_start_q,
		(count_q == '0) && !half_q && !failed_q && !brace_q)
	`ASSERT_IMPL(a_count_bound, clk, arst_n, count_q[utp_pkg::CNT_W-1],
		count_q == utp_pkg::BYTES_FULL)

endmodule

>>> rtl/utp_char_class.sv
module utp_char_class (
	input  logic [7:0]          character,
	output utp_pkg::char_class_t cls
);

	always_comb begin
		cls           = '0;
		cls.is_hyphen = (character == utp_pkg::CH_HYPHEN);
		cls.is_open   = (character == utp_pkg::CH_OPEN);
		cls.is_close  = (character == utp_pkg::CH_CLOSE);
		if (character inside {[8'h30:8'h39]}) begin
			cls.is_hex = 1'b1;
			cls.nibble = character[3:0];
		end else if (character inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			// letters A to F and a to f: low bits run 1..6, value runs 10..15
			cls.is_hex = 1'b1;
			cls.nibble = character[3:0] + 4'd9;
		end
	end

endmodule
